### hdl/six_register_execute_unit_defines.svh
// ============================================================================
// Assertion macros for the six-register execute unit
// Shared property wrappers; all of them compile away when NO_ASSERTIONS is set.
// ============================================================================
`ifndef SIX_REGISTER_EXECUTE_UNIT_DEFINES_SVH
`define SIX_REGISTER_EXECUTE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define SREU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked at every rising clock edge outside reset.
`define SREU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SREU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define SREU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### hdl/sreu_pkg.sv
// ============================================================================
// sreu_pkg
// Types, opcodes and stream layout shared by the execute unit and its RAM.
// ============================================================================
`default_nettype none

package sreu_pkg;

   // Parameter defaults.
   localparam int NUM_REGS_DEF   = 6;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int LINE_BITS_DEF  = 8;

   // Stream widths, fields packed from bit 0 up and padded to whole bytes.
   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 80;

   // Values of the func flag.
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_EXEC  = 1'b1;

   // Opcodes.
   localparam logic [3:0] OP_ADD      = 4'd0;
   localparam logic [3:0] OP_MOV      = 4'd1;
   localparam logic [3:0] OP_SUBB     = 4'd2;
   localparam logic [3:0] OP_MUL      = 4'd3;
   localparam logic [3:0] OP_DIV      = 4'd4;
   localparam logic [3:0] OP_JUMPME   = 4'd5;   // less than
   localparam logic [3:0] OP_JUMPMEIG = 4'd6;   // less or equal
   localparam logic [3:0] OP_JUMPMA   = 4'd7;   // greater than
   localparam logic [3:0] OP_JUMPMAIG = 4'd8;   // greater or equal
   localparam logic [3:0] OP_JUMPDIF  = 4'd9;   // not equal
   localparam logic [3:0] OP_JUMPIG   = 4'd10;  // equal
   localparam logic [3:0] OP_JUMP     = 4'd11;
   localparam logic [3:0] OP_PRINT    = 4'd12;

   // Cycle charges.
   localparam logic [31:0] CYC_KNOWN   = 32'd3;
   localparam logic [31:0] CYC_UNKNOWN = 32'd1;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_RDA,
      S_RDB,
      S_OPS,
      S_EXEC,
      S_MUL,
      S_WB,
      S_DIVB,
      S_DIV,
      S_FIX,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

### hdl/sreu_ram.sv
// ============================================================================
// sreu_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module sreu_ram
   import sreu_pkg::*;
#(
   parameter int WIDTH = DATA_WIDTH_DEF,
   parameter int DEPTH = NUM_REGS_DEF
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/six_register_execute_unit.sv
// ============================================================================
// six_register_execute_unit
// Executes one decoded instruction per item on a small signed register file.
// ============================================================================
// Usage:
//   Items enter on the req_ channel (tuser = func, tdata = decoded instruction)
//   and each one produces exactly one result item on the rsp_ channel.
//   A start item clears the register file and the cycle total and loads R1.
//   The block takes one item at a time; req_tready is high only while idle.
//   A start item writes R1 and then hands over its result. Other items read
//   the destination and source registers, pick the operand and execute;
//   multiply then runs its loop and writes the product, and divide takes the
//   divisor magnitude, runs its loop and fixes the quotient sign, unless the
//   divisor is zero. The block returns to idle before it takes the next item.
//   Multiply and divide run one bit a cycle through the single shared adder.
//   The result sits in an output register: a new item is accepted while it
//   waits, and the sequencer holds its next result until rsp_tready frees it.
//   Reset (synchronous, active high) empties the register file through its
//   valid bits, clears the cycle total, drops rsp_tvalid and returns to idle.
// ============================================================================
`default_nettype none

`include "six_register_execute_unit_defines.svh"

module six_register_execute_unit
   import sreu_pkg::*;
#(
   parameter int NUM_REGS   = NUM_REGS_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int LINE_BITS  = LINE_BITS_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   // Request channel.
   input  wire                    req_tvalid,
   output logic                   req_tready,
   // tdata from bit 0: opcode[3:0], dest_reg[6:4], src_is_reg[7], src_reg[10:8],
   // immediate[42:11], jump_target[50:43], start_value[82:51], zero pad[87:83]
   input  wire [REQ_TDATA_W-1:0]  req_tdata,
   // tuser: func[0]
   input  wire                    req_tuser,
   // Result channel.
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   // tdata from bit 0: branch_taken[0], branch_line[8:1], print_valid[9],
   // print_value[41:10], div_error[42], cycle_count[74:43], zero pad[79:75]
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int DW = DATA_WIDTH;
   localparam int AW = $clog2(NUM_REGS);
   localparam int CW = $clog2(DATA_WIDTH);

   // Request fields.
   logic [3:0]         f_opcode;
   logic [2:0]         f_dest;
   logic               f_src_is_reg;
   logic [2:0]         f_src;
   logic signed [31:0] f_imm;
   logic [7:0]         f_jump;
   logic signed [31:0] f_start;
   logic [7:0]         line_mask;

   assign f_opcode     = req_tdata[3:0];
   assign f_dest       = req_tdata[6:4];
   assign f_src_is_reg = req_tdata[7];
   assign f_src        = req_tdata[10:8];
   assign f_imm        = req_tdata[42:11];
   assign f_jump       = req_tdata[50:43];
   assign f_start      = req_tdata[82:51];
   assign line_mask    = 8'({LINE_BITS{1'b1}});

   // State and datapath registers.
   state_type         state_ff, state_in;
   logic [3:0]        op_ff, op_in;
   logic [AW-1:0]     didx_ff, didx_in;
   logic              dok_ff, dok_in;
   logic [AW-1:0]     sidx_ff, sidx_in;
   logic              sok_ff, sok_in;
   logic              sreg_ff, sreg_in;
   logic [DW-1:0]     val_ff, val_in;
   logic [7:0]        jump_ff, jump_in;
   logic              rdok_ff, rdok_in;
   logic [DW-1:0]     a_ff, a_in;
   logic [DW-1:0]     b_ff, b_in;
   logic [DW-1:0]     acc_ff, acc_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic [NUM_REGS-1:0] valid_ff, valid_in;
   logic [31:0]       cyc_ff, cyc_in;
   logic              taken_ff, taken_in;
   logic              pvalid_ff, pvalid_in;
   logic [31:0]       pvalue_ff, pvalue_in;
   logic              derr_ff, derr_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // Register file RAM ports.
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [DW-1:0] ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [DW-1:0] ram_rdata;

   // Shared adder / subtractor.
   logic [DW-1:0] add_x;
   logic [DW-1:0] add_y;
   logic          add_sub;
   logic [DW:0]   add_full;
   logic [DW-1:0] add_out;
   logic          add_carry;

   // Compare flags and misc.
   logic          lt_flag;
   logic          eq_flag;
   logic [DW-1:0] rem_sh;
   logic [32:0]   cyc_sum;
   logic          req_fire;

   assign req_fire = req_tvalid && req_tready;

   sreu_ram #(
      .WIDTH (DW),
      .DEPTH (NUM_REGS)
   ) u_regs (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Operand selection for the shared adder.
   always_comb begin
      add_x   = a_ff;
      add_y   = b_ff;
      add_sub = 1'b1;
      case (state_ff)
         S_EXEC: begin
            if (op_ff == OP_ADD) begin
               add_sub = 1'b0;
            end else if (op_ff == OP_DIV) begin
               add_x = '0;
               add_y = a_ff;
            end
         end
         S_DIVB: begin
            add_x = '0;
            add_y = b_ff;
         end
         S_MUL: begin
            add_x   = acc_ff;
            add_y   = a_ff;
            add_sub = 1'b0;
         end
         S_DIV: begin
            add_x = rem_sh;
            add_y = b_ff;
         end
         S_FIX: begin
            add_x = '0;
            add_y = a_ff;
         end
         default: begin
            add_x = a_ff;
         end
      endcase
   end

   assign add_full  = {1'b0, add_x} + {1'b0, add_y ^ {DW{add_sub}}} + (DW+1)'(add_sub);
   assign add_out   = add_full[DW-1:0];
   assign add_carry = add_full[DW];

   // Signed compare from the subtractor: sign of a - b corrected for overflow.
   assign lt_flag = add_out[DW-1]
                    ^ ((a_ff[DW-1] != b_ff[DW-1]) && (add_out[DW-1] != a_ff[DW-1]));
   assign eq_flag = (a_ff == b_ff);

   // Partial remainder shifted left with the next dividend bit.
   assign rem_sh = {acc_ff[DW-2:0], a_ff[DW-1]};

   // Saturating cycle total.
   assign cyc_sum = {1'b0, cyc_ff} + {1'b0, ((op_ff <= OP_PRINT) ? CYC_KNOWN : CYC_UNKNOWN)};

   // Sequencer: next state and datapath control.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      didx_in       = didx_ff;
      dok_in        = dok_ff;
      sidx_in       = sidx_ff;
      sok_in        = sok_ff;
      sreg_in       = sreg_ff;
      val_in        = val_ff;
      jump_in       = jump_ff;
      rdok_in       = rdok_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      acc_in        = acc_ff;
      cnt_in        = cnt_ff;
      neg_in        = neg_ff;
      valid_in      = valid_ff;
      cyc_in        = cyc_ff;
      taken_in      = taken_ff;
      pvalid_in     = pvalid_ff;
      pvalue_in     = pvalue_ff;
      derr_in       = derr_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      ram_we        = 1'b0;
      ram_waddr     = didx_ff;
      ram_wdata     = add_out;
      ram_raddr     = sidx_ff;
      req_tready    = (state_ff == S_IDLE);

      // The taken result leaves the output register.
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in     = f_opcode;
               didx_in   = AW'(3'(f_dest - 3'd1));
               dok_in    = (f_dest != 3'd0) && (5'(f_dest) <= 5'(NUM_REGS));
               sidx_in   = AW'(3'(f_src - 3'd1));
               sok_in    = (f_src != 3'd0) && (5'(f_src) <= 5'(NUM_REGS));
               sreg_in   = f_src_is_reg;
               val_in    = (req_tuser == FUNC_START) ? DW'(f_start) : DW'(f_imm);
               jump_in   = f_jump & line_mask;
               taken_in  = 1'b0;
               pvalid_in = 1'b0;
               pvalue_in = '0;
               derr_in   = 1'b0;
               state_in  = (req_tuser == FUNC_START) ? S_START : S_RDA;
            end
         end
         // Start item: empty the file, load R1, zero the cycle total.
         S_START: begin
            ram_we      = 1'b1;
            ram_waddr   = '0;
            ram_wdata   = val_ff;
            valid_in    = '0;
            valid_in[0] = 1'b1;
            cyc_in      = '0;
            state_in    = S_DONE;
         end
         // Read the destination register.
         S_RDA: begin
            ram_raddr = didx_ff;
            rdok_in   = dok_ff && valid_ff[didx_ff];
            state_in  = S_RDB;
         end
         // Destination data arrives; read the source register.
         S_RDB: begin
            ram_raddr = sidx_ff;
            a_in      = rdok_ff ? ram_rdata : '0;
            rdok_in   = sok_ff && valid_ff[sidx_ff];
            state_in  = S_OPS;
         end
         // Source operand: register data or the immediate.
         S_OPS: begin
            if (sreg_ff) begin
               b_in = rdok_ff ? ram_rdata : '0;
            end else begin
               b_in = val_ff;
            end
            state_in = S_EXEC;
         end
         // Single-step operations, and setup of the iterative ones.
         S_EXEC: begin
            cyc_in   = cyc_sum[32] ? '1 : cyc_sum[31:0];
            state_in = S_DONE;
            case (op_ff)
               OP_ADD, OP_SUBB: begin
                  ram_we = dok_ff;
               end
               OP_MOV: begin
                  ram_we    = dok_ff;
                  ram_wdata = b_ff;
               end
               OP_MUL: begin
                  acc_in   = '0;
                  cnt_in   = CW'(DW - 1);
                  state_in = S_MUL;
               end
               OP_DIV: begin
                  if (b_ff == '0) begin
                     derr_in = 1'b1;
                  end else begin
                     neg_in   = a_ff[DW-1] ^ b_ff[DW-1];
                     a_in     = a_ff[DW-1] ? add_out : a_ff;
                     state_in = S_DIVB;
                  end
               end
               OP_JUMPME:   taken_in = lt_flag;
               OP_JUMPMEIG: taken_in = lt_flag || eq_flag;
               OP_JUMPMA:   taken_in = !lt_flag && !eq_flag;
               OP_JUMPMAIG: taken_in = !lt_flag;
               OP_JUMPDIF:  taken_in = !eq_flag;
               OP_JUMPIG:   taken_in = eq_flag;
               OP_JUMP:     taken_in = 1'b1;
               OP_PRINT: begin
                  pvalid_in = 1'b1;
                  pvalue_in = 32'(signed'(a_ff));
               end
               default: begin
                  taken_in = 1'b0;
               end
            endcase
         end
         // Shift-and-add multiply, one multiplier bit a cycle.
         S_MUL: begin
            if (b_ff[0]) begin
               acc_in = add_out;
            end
            a_in = {a_ff[DW-2:0], 1'b0};
            b_in = {1'b0, b_ff[DW-1:1]};
            if (cnt_ff == '0) begin
               state_in = S_WB;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         // Write the product.
         S_WB: begin
            ram_we    = dok_ff;
            ram_wdata = acc_ff;
            state_in  = S_DONE;
         end
         // Divisor magnitude; clear the partial remainder.
         S_DIVB: begin
            b_in     = b_ff[DW-1] ? add_out : b_ff;
            acc_in   = '0;
            cnt_in   = CW'(DW - 1);
            state_in = S_DIV;
         end
         // Restoring division on magnitudes, one quotient bit a cycle.
         S_DIV: begin
            acc_in = add_carry ? add_out : rem_sh;
            a_in   = {a_ff[DW-2:0], add_carry};
            if (cnt_ff == '0) begin
               state_in = S_FIX;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         // Apply the quotient sign and write it.
         S_FIX: begin
            ram_we    = dok_ff;
            ram_wdata = neg_ff ? add_out : a_ff;
            state_in  = S_DONE;
         end
         // Hand the result to the output register once it is free.
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {5'd0, cyc_ff, derr_ff, pvalue_ff, pvalid_ff,
                                (taken_ff ? jump_ff : 8'd0), taken_ff};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A write makes its entry valid.
      if (ram_we && (state_ff != S_START)) begin
         valid_in[ram_waddr] = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         cyc_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         cyc_ff        <= cyc_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      didx_ff      <= didx_in;
      dok_ff       <= dok_in;
      sidx_ff      <= sidx_in;
      sok_ff       <= sok_in;
      sreg_ff      <= sreg_in;
      val_ff       <= val_in;
      jump_ff      <= jump_in;
      rdok_ff      <= rdok_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      acc_ff       <= acc_in;
      cnt_ff       <= cnt_in;
      neg_ff       <= neg_in;
      taken_ff     <= taken_in;
      pvalid_ff    <= pvalid_in;
      pvalue_ff    <= pvalue_in;
      derr_ff      <= derr_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Checks on the sequencer and datapath.
   `SREU_ASSERT_NXT(a_busy_after_accept, clock, reset, req_fire, !req_tready, "ready after accept")
   `SREU_ASSERT_IMP(a_div_nonzero, clock, reset, state_ff == S_DIV, b_ff != '0, "zero divisor in loop")
   `SREU_ASSERT_IMP(a_write_in_range, clock, reset, ram_we, ram_waddr < NUM_REGS, "write out of range")
   `SREU_ASSERT_NXT(a_cycles_grow, clock, reset, state_ff == S_EXEC, cyc_ff >= $past(cyc_ff), "cycle total fell")
   `SREU_ASSERT_IMP(a_rsp_from_done, clock, reset, $rose(rsp_tvalid_ff), $past(state_ff == S_DONE), "result not from done")

endmodule

`default_nettype wire
